/* rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int QueueDepth = 2;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_CMP = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DIV = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// classified request handed from front to back
	typedef struct packed {
		logic        direct;   // result already known
		logic [1:0]  d_order;
		status_t     d_status;
		logic        is_cmp;
		logic [2:0]  kind;
		logic [31:0] a_num;
		logic [30:0] a_den;
		logic [31:0] b_num;
		logic [30:0] b_den;
	} req_t;

	typedef enum logic [3:0] {
		B_IDLE, B_MUL1, B_MUL2, B_SUM, B_GCD_INIT, B_GCD, B_DIVN, B_DIVD, B_CHECK, B_OUT
	} bstate_t;

endpackage

/* rtl/rau_front.sv */
// ----------------------------------------------------------------------------
// rau_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rau_front import rau_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  kind,
	input  logic [31:0] a_num,
	input  logic [30:0] a_den,
	input  logic [31:0] b_num,
	input  logic [30:0] b_den,
	output logic        q_valid,
	input  logic        q_take,
	output req_t        q_req
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	req_t            mem_q [Depth];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	req_t            cls;
	logic            wr, rd;

	always_comb begin
		cls = '0;
		cls.kind = kind;
		cls.a_num = a_num;
		cls.a_den = a_den;
		cls.b_num = b_num;
		cls.b_den = b_den;
		cls.is_cmp = (kind == KIND_CMP);
		cls.d_status = ST_OK;
		if (kind > KIND_CMP) begin
			cls.direct = 1'b1;
		end else if (a_den == '0 || b_den == '0 || (kind == KIND_DIV && b_num == '0)) begin
			cls.direct = 1'b1;
			cls.d_status = ST_ZERO_DIV;
		end
	end

	assign full    = (cnt_q == (AW+1)'(Depth));
	assign q_valid = (cnt_q != '0);
	assign wr      = push && !full;
	assign rd      = q_take && q_valid;
	assign q_req   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

endmodule

/* rtl/rau_back.sv */
// ----------------------------------------------------------------------------
// rau_back
// Forms cross products, reduces by Euclidean GCD with a bit-serial divider,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module rau_back import rau_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_take,
	input  req_t               q_req,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic signed [1:0]  order,
	output logic [1:0]         status
);
	bstate_t            state_q, state_d;
	req_t               req_q;
	logic signed [63:0] p1_q, p2_q;
	logic signed [63:0] n_q;
	logic [63:0]        d_q;
	logic               neg_q;
	logic [63:0]        x_q, y_q;      // gcd operands
	logic [63:0]        dv_q, quo_q, rem_q;
	logic [6:0]         bit_q;
	logic               gdiv_q;        // gcd remainder phase
	logic               out_v_q;
	logic [31:0]        o_num_q;
	logic [30:0]        o_den_q;
	logic [1:0]         o_ord_q;
	logic [1:0]         o_st_q;

	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic [64:0]        trial;
	logic [63:0]        un;

	assign empty   = !out_v_q;
	assign res_num = o_num_q;
	assign res_den = o_den_q;
	assign order   = o_ord_q;
	assign status  = o_st_q;
	assign q_take  = (state_q == B_IDLE) && q_valid && !out_v_q;
	assign un      = n_q[63] ? (64'd0 - 64'(n_q)) : 64'(n_q);
	assign trial   = {rem_q, quo_q[63]} - {1'b0, dv_q};

	// one multiplier, two products in states B_MUL1 and B_MUL2
	always_comb begin
		ma = '0;
		mb = '0;
		if (state_q == B_MUL1) begin
			ma = req_q.a_num;
			mb = (req_q.kind == KIND_MUL) ? req_q.b_num : $signed({1'b0, req_q.b_den});
		end else begin
			ma = (req_q.kind == KIND_DIV) ? $signed({1'b0, req_q.a_den}) : req_q.b_num;
			mb = (req_q.kind == KIND_DIV) ? req_q.b_num : $signed({1'b0, req_q.a_den});
		end
		prod = ma * mb;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (q_take) begin
					state_d = q_req.direct ? B_OUT : B_MUL1;
				end
			end
			B_MUL1:     state_d = B_MUL2;
			B_MUL2:     state_d = B_SUM;
			B_SUM:      state_d = req_q.is_cmp ? B_OUT : B_GCD_INIT;
			B_GCD_INIT: state_d = (un == '0) ? B_OUT : B_GCD;
			B_GCD: begin
				if (!gdiv_q && y_q == '0) begin
					state_d = B_DIVN;
				end
			end
			B_DIVN: begin
				if (bit_q == 7'd64) begin
					state_d = B_DIVD;
				end
			end
			B_DIVD: begin
				if (bit_q == 7'd64) begin
					state_d = B_CHECK;
				end
			end
			B_CHECK:    state_d = B_OUT;
			B_OUT: begin
				if (!out_v_q) begin
					state_d = B_IDLE;
				end
			end
			default:    state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			if (state_q == B_OUT && !out_v_q) begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_take) begin
					req_q <= q_req;
					o_num_q <= '0;
					o_den_q <= '0;
					o_ord_q <= '0;
					o_st_q <= q_req.d_status;
				end
			end
			B_MUL1: p1_q <= prod;
			B_MUL2: p2_q <= prod;
			B_SUM: begin
				if (req_q.is_cmp) begin
					o_ord_q <= (p1_q < p2_q) ? 2'b11 : ((p1_q > p2_q) ? 2'b01 : 2'b00);
				end
				case (req_q.kind)
					KIND_ADD: n_q <= p1_q + p2_q;
					KIND_SUB: n_q <= p1_q - p2_q;
					default:  n_q <= p1_q;
				endcase
				// denominator a_den*b_den (positive) or a_den*b_num (signed)
				if (req_q.kind == KIND_DIV) begin
					neg_q <= p2_q[63];
					d_q <= p2_q[63] ? 64'd0 - 64'(p2_q) : 64'(p2_q);
				end else begin
					neg_q <= 1'b0;
					d_q <= 64'(req_q.a_den) * 64'(req_q.b_den);
				end
			end
			B_GCD_INIT: begin
				neg_q <= neg_q ^ n_q[63];
				n_q <= $signed(un);
				x_q <= un;
				y_q <= d_q;
				gdiv_q <= 1'b0;
				if (un == '0) begin
					o_den_q <= 31'd1;
				end
			end
			B_GCD: begin
				if (!gdiv_q) begin
					if (y_q != '0) begin
						gdiv_q <= 1'b1;
						quo_q <= x_q;
						rem_q <= '0;
						dv_q <= y_q;
						bit_q <= '0;
					end else begin
						dv_q <= x_q;
						quo_q <= 64'(n_q);
						rem_q <= '0;
						bit_q <= '0;
					end
				end else if (bit_q == 7'd64) begin
					x_q <= y_q;
					y_q <= rem_q;
					gdiv_q <= 1'b0;
				end else begin
					rem_q <= trial[64] ? {rem_q[62:0], quo_q[63]} : trial[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
					bit_q <= bit_q + 7'd1;
				end
			end
			B_DIVN: begin
				if (bit_q == 7'd64) begin
					n_q <= $signed(quo_q);
					quo_q <= d_q;
					rem_q <= '0;
					bit_q <= '0;
				end else begin
					rem_q <= trial[64] ? {rem_q[62:0], quo_q[63]} : trial[63:0];
					quo_q <= {quo_q[62:0], !trial[64]};
					bit_q <= bit_q + 7'd1;
				end
			end
			B_DIVD: begin
				if (bit_q == 7'd64) begin
					d_q <= quo_q;
				end else begin
					rem_q <= trial[64] ? {rem_q[62:0], quo_q[63]} : trial[63:0];
					quo_q <= {quo_q[62:0], !trial[64]};
					bit_q <= bit_q + 7'd1;
				end
			end
			B_CHECK: begin
				if (d_q > 64'h7FFF_FFFF ||
				    (neg_q ? 64'(n_q) > 64'h8000_0000 : 64'(n_q) > 64'h7FFF_FFFF)) begin
					o_st_q <= ST_OVERFLOW;
				end else begin
					o_num_q <= neg_q ? 32'd0 - n_q[31:0] : n_q[31:0];
					o_den_q <= d_q[30:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/rational_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Exact fraction add, subtract, multiply, divide and compare with reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive kind and the two fractions with push while
//   full is low. Result side is a queue: res_num, res_den, order and status
//   are valid while empty is low; pop takes them.
//   A front end classifies requests (undefined kind, zero denominator,
//   divide by zero) into a short queue; a back end computes one request at
//   a time with a single 32x32 multiplier and a bit-serial 64-bit divider.
// Steps: two cross products, then sum or compare; requests resolved up front
//   skip them. Then Euclidean GCD, dividing numerator and denominator by it,
//   and an overflow check; compare and a zero numerator skip these.
// Throughput: the back end works on one request at a time and takes the next
//   only once the held result is popped; the front queue keeps accepting.
// Reset: arst_n clears both queues and the back end state machine.
// Stall: a held result blocks the back end; the front queue fills, then full.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top import rau_pkg::*; #(
	parameter int Depth = QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [2:0]         kind,
	input  logic signed [31:0] a_num,
	input  logic [30:0]        a_den,
	input  logic signed [31:0] b_num,
	input  logic [30:0]        b_den,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic signed [1:0]  order,
	output logic [1:0]         status
);
	logic q_valid, q_take;
	req_t q_req;

	rau_front #(.Depth(Depth)) u_front (
		.clk, .arst_n, .push, .full, .kind, .a_num, .a_den, .b_num, .b_den,
		.q_valid, .q_take, .q_req
	);

	rau_back u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_req, .empty, .pop,
		.res_num, .res_den, .order, .status
	);

endmodule
